// ----- rtl/ghash_pkg.sv -----
// ----------------------------------------------------------------------------
// ghash_pkg: shared types and constants of the GHASH accumulator
// Widths, the GCM reduction constant, configuration register indexes and the
// byte mask that zero-pads a partial block.
// ----------------------------------------------------------------------------
package ghash_pkg;

  // Field and block widths.
  localparam int WordW      = 64;
  localparam int BlockW     = 2 * WordW;
  localparam int BlockBytes = BlockW / 8;
  localparam int CountW     = 5;
  localparam int CfgIdxW    = 1;

  // Reduction constant R = 0xe1 followed by 120 zero bits, in GCM bit order.
  localparam logic [BlockW-1:0] RedPoly = {8'he1, {(BlockW - 8){1'b0}}};

  typedef logic [BlockW-1:0] block_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgSubkeyHigh = 1'b0,
    CfgSubkeyLow  = 1'b1
  } cfg_reg_t;

  // Keeps the leading count bytes of a block, byte 0 being the most
  // significant. A count of sixteen or more keeps the whole block.
  function automatic block_t lead_mask(input logic [CountW-1:0] count);
    block_t mask;
    mask = '0;
    for (int j = 0; j < BlockBytes; j++) begin
      if (CountW'(j) < count) begin
        mask[BlockW-1-8*j -: 8] = 8'hff;
      end
    end
    return mask;
  endfunction

endpackage

// ----- rtl/ghash_gfmul.sv -----
// ----------------------------------------------------------------------------
// ghash_gfmul: combinational multiplier in GF(2^128)
// Computes a * h in the GCM bit order, where bit 0 of a block is the most
// significant bit of byte 0 and the field polynomial is reduced through R.
// ----------------------------------------------------------------------------
module ghash_gfmul (
  input  ghash_pkg::block_t a,
  input  ghash_pkg::block_t h,
  output ghash_pkg::block_t z
);

  localparam int BlockW = ghash_pkg::BlockW;

  // Multiples of h by successive powers of x; each is the previous one
  // shifted one place towards the low end, with R folded in on overflow.
  ghash_pkg::block_t hpow [BlockW];

  assign hpow[0] = h;

  for (genvar i = 0; i < BlockW - 1; i++) begin : g_pow
    assign hpow[i+1] = (hpow[i] >> 1) ^ (hpow[i][0] ? ghash_pkg::RedPoly : '0);
  end

  // Sum of the multiples selected by the bits of a, bit 0 first.
  always_comb begin
    z = '0;
    for (int i = 0; i < BlockW; i++) begin
      if (a[BlockW-1-i]) begin
        z = z ^ hpow[i];
      end
    end
  end

endmodule

// ----- rtl/ghash_accumulator.sv -----
// ----------------------------------------------------------------------------
// ghash_accumulator: GCM GHASH accumulator
// Absorbs one 128-bit block per item into Y = (Y xor X) * H and returns the
// updated Y for every item.
// ----------------------------------------------------------------------------
// Each item passes through two registers: the masked block is captured at the
// input, and then the GF(2^128) product is written into the accumulator, which
// also serves as the result register. One item is taken every cycle while the
// output channel does not stall; the result is presented from the accumulator
// once the item has left the input register. The rate is set by the feedback
// of the accumulator through the combinational multiplier. A set start_req
// clears Y before that block is absorbed, and bytes at or beyond byte_count are
// taken as zero. The subkey words may be written only while no item is in
// flight.
// ----------------------------------------------------------------------------
module ghash_accumulator (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration port
  input  logic                                cfg_we,
  input  logic [ghash_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [ghash_pkg::WordW-1:0]         cfg_data,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                start_req,
  input  logic [ghash_pkg::WordW-1:0]         data_high,
  input  logic [ghash_pkg::WordW-1:0]         data_low,
  input  logic [ghash_pkg::CountW-1:0]        byte_count,
  // Output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ghash_pkg::WordW-1:0]         hash_high,
  output logic [ghash_pkg::WordW-1:0]         hash_low
);

  localparam int WordW  = ghash_pkg::WordW;
  localparam int BlockW = ghash_pkg::BlockW;

  logic [WordW-1:0]  subkey_high;
  logic [WordW-1:0]  subkey_low;

  logic              s1_valid;
  logic              s1_start;
  ghash_pkg::block_t s1_x;

  ghash_pkg::block_t acc;
  ghash_pkg::block_t acc_next;
  ghash_pkg::block_t mul_a;

  logic              out_free;
  logic              in_fire;
  logic              s1_fire;

  // Handshake: the result register frees when empty or being taken.
  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_fire  = in_valid && !in_stall;

  // Subkey registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      subkey_high <= '0;
      subkey_low  <= '0;
    end else if (cfg_we) begin
      unique case (ghash_pkg::cfg_reg_t'(cfg_index))
        ghash_pkg::CfgSubkeyHigh: subkey_high <= cfg_data;
        ghash_pkg::CfgSubkeyLow:  subkey_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: the block is zero-padded as it is captured.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_start <= start_req;
      s1_x     <= {data_high, data_low} & ghash_pkg::lead_mask(byte_count);
    end
  end

  // Multiplier operand: the block xored with the previous hash, or with zero on a start item.
  assign mul_a = (s1_start ? '0 : acc) ^ s1_x;

  ghash_gfmul u_gfmul (
    .a (mul_a),
    .h ({subkey_high, subkey_low}),
    .z (acc_next)
  );

  // Accumulator, which is also the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      acc       <= acc_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign hash_high = acc[BlockW-1:WordW];
  assign hash_low  = acc[WordW-1:0];

`ifndef SYNTH
  // The input side stalls only while an item waits in the input register.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with an empty input register");

  // An item leaving the input register always shows up as a result.
  a_item_reaches_out: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_valid)
    else $error("item lost between input register and result");

  // A start item with an all-zero block hashes to zero.
  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_start && (s1_x == '0)) |=> (acc == '0))
    else $error("start item with empty block did not clear the hash");

  // A zero subkey gives a zero product.
  a_zero_subkey: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && (subkey_high == '0) && (subkey_low == '0)) |=> (acc == '0))
    else $error("zero subkey gave a nonzero hash");

  // Nothing is in flight straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!s1_valid && !out_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the GHASH accumulator
// Drives partial and full blocks through the valid/stall input channel,
// predicts every updated hash Y = (Y xor X) * H and compares it, half by half,
// with the results taken from the output channel. Several subkeys are loaded
// through the write port, among them zero, all ones and the field's identity.
// ----------------------------------------------------------------------------
module tb;

  localparam int WordW   = ghash_pkg::WordW;
  localparam int BlockW  = ghash_pkg::BlockW;
  localparam int CountW  = ghash_pkg::CountW;
  localparam int CfgIdxW = ghash_pkg::CfgIdxW;

  typedef ghash_pkg::block_t block_t;

  localparam int CycleLimit  = 200000;
  localparam int StallPct    = 21;
  localparam int PhaseBlocks = 108;

  // Running hash predictor with a queue of hashes still to come out.
  class ghash_tracker;
    block_t subkey;
    block_t acc;
    block_t pending_hash[$];
    int     mismatch_count;
    int     hashes_checked;

    function new();
      subkey         = '0;
      acc            = '0;
      mismatch_count = 0;
      hashes_checked = 0;
    endfunction

    // Product in GF(2^128), GCM bit order: bit 127 is the lowest power.
    function block_t gf_mult(block_t a, block_t b);
      block_t prod;
      block_t v;
      logic   carry;
      prod = '0;
      v    = b;
      for (int i = BlockW - 1; i >= 0; i--) begin
        if (a[i]) begin
          prod ^= v;
        end
        carry = v[0];
        v     = v >> 1;
        if (carry) begin
          v ^= ghash_pkg::RedPoly;
        end
      end
      return prod;
    endfunction

    // Keeps the leading bytes of a block; counts above sixteen keep it all.
    function block_t block_mask(logic [CountW-1:0] count);
      int n;
      n = (count > 16) ? 16 : int'(count);
      if (n == 0) begin
        return block_t'(0);
      end
      return ~block_t'(0) << (BlockW - 8 * n);
    endfunction

    // Absorbs an accepted item and queues the hash it must produce.
    function void note_block(logic start, logic [WordW-1:0] dh, logic [WordW-1:0] dl,
                             logic [CountW-1:0] count);
      if (start) begin
        acc = '0;
      end
      acc = gf_mult(acc ^ ({dh, dl} & block_mask(count)), subkey);
      pending_hash.push_back(acc);
    endfunction

    task report(string what);
      mismatch_count++;
      if (mismatch_count <= 30) begin
        $display("MISMATCH at %0t: %s", $time, what);
      end
    endtask

    // Compares a result with the oldest hash waiting.
    task check_hash(logic [WordW-1:0] hh, logic [WordW-1:0] hl);
      block_t want;
      if (pending_hash.size() == 0) begin
        report($sformatf("unexpected hash %h_%h", hh, hl));
        return;
      end
      want = pending_hash.pop_front();
      hashes_checked++;
      if (hh !== want[BlockW-1:WordW]) begin
        report($sformatf("hash_high %h, expected %h", hh, want[BlockW-1:WordW]));
      end
      if (hl !== want[WordW-1:0]) begin
        report($sformatf("hash_low %h, expected %h", hl, want[WordW-1:0]));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst        = 1'b1;
  logic                 cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index  = ghash_pkg::CfgSubkeyHigh;
  logic [WordW-1:0]     cfg_data   = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic                 start_req  = 1'b0;
  logic [WordW-1:0]     data_high  = '0;
  logic [WordW-1:0]     data_low   = '0;
  logic [CountW-1:0]    byte_count = CountW'(16);
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [WordW-1:0]     hash_high;
  logic [WordW-1:0]     hash_low;

  ghash_tracker tracker = new();
  logic         allow_idle    = 1'b1;
  int           blocks_sent   = 0;
  int           subkeys_used  = 0;
  int           cycle_count   = 0;

  ghash_accumulator u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .start_req  (start_req),
    .data_high  (data_high),
    .data_low   (data_low),
    .byte_count (byte_count),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_high  (hash_high),
    .hash_low   (hash_low)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure, switched off during the quiet stretch.
  always @(posedge clk) begin
    out_stall <= allow_idle && ($urandom_range(99) < StallPct);
  end

  // Watches both channels: results are checked before the item of the same
  // edge is absorbed, which cannot matter given the pipeline depth.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        tracker.check_hash(hash_high, hash_low);
      end
      if (in_valid && !in_stall) begin
        tracker.note_block(start_req, data_high, data_low, byte_count);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("ghash_accumulator test failed");
      $finish;
    end
  end

  // Offers one item, after a random gap, and returns at the edge it is taken.
  task automatic send_block(input logic start, input logic [WordW-1:0] dh,
                            input logic [WordW-1:0] dl, input logic [CountW-1:0] count);
    while (allow_idle && ($urandom_range(99) < StallPct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    start_req  <= start;
    data_high  <= dh;
    data_low   <= dl;
    byte_count <= count;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    blocks_sent++;
  endtask

  // Stops sending and waits until every hash has come out, plus the latency.
  task automatic drain();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (tracker.pending_hash.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Loads both subkey words; only called with nothing in flight.
  task automatic load_subkey(input block_t h);
    cfg_we    <= 1'b1;
    cfg_index <= ghash_pkg::CfgSubkeyHigh;
    cfg_data  <= h[BlockW-1:WordW];
    @(posedge clk);
    cfg_index <= ghash_pkg::CfgSubkeyLow;
    cfg_data  <= h[WordW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.subkey = h;
    subkeys_used++;
  endtask

  // Mostly whole messages opened by a start flag and sometimes closed by a partial
  // block, with some stray blocks of any flag and count in between.
  task automatic random_phase(input int n, input bit with_pause);
    int target;
    int len;
    target = blocks_sent + n;
    while (blocks_sent < target) begin
      if (with_pause && blocks_sent >= target - n / 2) begin
        drain();
        with_pause = 1'b0;
      end
      if ($urandom_range(9) < 8) begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          send_block(k == 0, {$urandom, $urandom}, {$urandom, $urandom},
                     (k == len - 1 && $urandom_range(1) == 1) ?
                       CountW'($urandom_range(1, 16)) : CountW'(16));
        end
      end else begin
        send_block(1'($urandom_range(1)), {$urandom, $urandom}, {$urandom, $urandom},
                   CountW'($urandom_range(31)));
      end
    end
  endtask

  // Reset, directed blocks, then random phases under several subkeys.
  initial begin
    int counts[9];
    counts = '{0, 1, 7, 8, 9, 15, 16, 17, 31};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every interesting count on all-ones data, plus edge patterns.
    load_subkey({$urandom, $urandom, $urandom, $urandom} | 128'h1);
    send_block(1'b1, '0, '0, CountW'(16));
    foreach (counts[i]) begin
      send_block(i == 0, '1, '1, CountW'(counts[i]));
    end
    send_block(1'b0, 64'h8000_0000_0000_0000, '0, CountW'(1));
    send_block(1'b0, 64'h1, 64'h1, CountW'(16));
    send_block(1'b1, '1, '1, CountW'(16));
    send_block(1'b0, '0, 64'h8000_0000_0000_0000, CountW'(9));
    send_block(1'b1, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, CountW'(12));
    send_block(1'b0, '1, '0, CountW'(0));
    drain();

    // Zero subkey: every hash collapses to zero.
    load_subkey('0);
    random_phase(PhaseBlocks, 1'b0);
    drain();

    // All-ones subkey.
    load_subkey('1);
    random_phase(PhaseBlocks, 1'b0);
    drain();

    // Identity element, run without any idling on either side.
    allow_idle <= 1'b0;
    load_subkey({1'b1, {(BlockW - 1){1'b0}}});
    random_phase(PhaseBlocks, 1'b0);
    drain();
    allow_idle <= 1'b1;

    // Highest power alone, with a full pause half way through.
    load_subkey(block_t'(1));
    random_phase(PhaseBlocks, 1'b1);
    drain();

    // Random subkeys.
    repeat (2) begin
      load_subkey({$urandom, $urandom, $urandom, $urandom});
      random_phase(PhaseBlocks, 1'b0);
      drain();
    end

    repeat (8) @(posedge clk);
    $display("Sent %0d blocks under %0d subkeys; %0d hashes checked, %0d mismatches.",
             blocks_sent, subkeys_used, tracker.hashes_checked, tracker.mismatch_count);
    if (tracker.mismatch_count == 0 && tracker.pending_hash.size() == 0) begin
      $display("ghash_accumulator test passed");
    end else begin
      $display("ghash_accumulator test failed");
    end
    $finish;
  end

endmodule

// ----- ghash_accumulator.f -----
rtl/ghash_pkg.sv
rtl/ghash_gfmul.sv
rtl/ghash_accumulator.sv
tb/tb.sv
